FILE: rtl/stxa_pkg.sv
// Shared types, constants and colour matching table builder for the XYZ accumulator.
package stxa_pkg;

  localparam int TABLE_ENTRIES = 471;
  localparam int NODE_COUNT = 95;
  localparam int BANK_EVEN = (TABLE_ENTRIES + 1) / 2;
  localparam int BANK_ODD = TABLE_ENTRIES / 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] NORM_SCALE_RESET = 32'd10048406;
  localparam logic [17:0] WL_MIN_Q8 = 18'd92160;
  localparam logic [17:0] WL_MAX_Q8 = 18'd212480;

  localparam int RESP_W = 26;
  localparam int PROD_W = 58;
  localparam int QUO_W = 34;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_INVALID = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [31:0] mag;
    logic        neg;
    logic [8:0]  idx;
    logic [7:0]  frac;
    logic [31:0] pdf;
    logic        invalid;
    logic        last;
  } item_t;

  typedef logic [53:0] cmf_word_t;
  typedef cmf_word_t even_bank_t [BANK_EVEN];
  typedef cmf_word_t odd_bank_t [BANK_ODD];

  // CIE 1931 nodes at 5 nm from 360 nm, units of 1e-9, stored x, y, z per node.
  localparam longint CIE_NODES [3*NODE_COUNT] = '{
    129900, 3917, 606100, 232100, 6965, 1086000, 414900, 12390, 1946000,
    741600, 22020, 3486000, 1368000, 39000, 6450000, 2236000, 64000, 10550000,
    4243000, 120000, 20050000, 7650000, 217000, 36210000, 14310000, 396000, 67850000,
    23190000, 640000, 110200000, 43510000, 1210000, 207400000,
    77630000, 2180000, 371300000,
    134380000, 4000000, 645600000, 214770000, 7300000, 1039050000,
    283900000, 11600000, 1385600000,
    328500000, 16840000, 1622960000, 348280000, 23000000, 1747060000,
    348060000, 29800000, 1782600000,
    336200000, 38000000, 1772110000, 318700000, 48000000, 1744100000,
    290800000, 60000000, 1669200000,
    251100000, 73900000, 1528100000, 195360000, 90980000, 1287640000,
    142100000, 112600000, 1041900000,
    95640000, 139020000, 812950000, 57950000, 169300000, 616200000,
    32010000, 208020000, 465180000,
    14700000, 258600000, 353300000, 4900000, 323000000, 272000000,
    2400000, 407300000, 212300000,
    9300000, 503000000, 158200000, 29100000, 608200000, 111700000,
    63270000, 710000000, 78250000,
    109600000, 793200000, 57250000, 165500000, 862000000, 42160000,
    225750000, 914850000, 29840000,
    290400000, 954000000, 20300000, 359700000, 980300000, 13400000,
    433450000, 994950000, 8750000,
    512050000, 1000000000, 5750000, 594500000, 995000000, 3900000,
    678400000, 978600000, 2750000,
    762100000, 952000000, 2100000, 842500000, 915400000, 1800000,
    916300000, 870000000, 1650000,
    978600000, 816300000, 1400000, 1026300000, 757000000, 1100000,
    1056700000, 694900000, 1000000,
    1062200000, 631000000, 800000, 1045600000, 566800000, 600000,
    1002600000, 503000000, 340000,
    938400000, 441200000, 240000, 854450000, 381000000, 190000,
    751400000, 321000000, 100000,
    642400000, 265000000, 50000, 541900000, 217000000, 30000,
    447900000, 175000000, 20000,
    360800000, 138200000, 10000, 283500000, 107000000, 0, 218700000, 81600000, 0,
    164900000, 61000000, 0, 121200000, 44580000, 0, 87400000, 32000000, 0,
    63600000, 23200000, 0, 46770000, 17000000, 0, 32900000, 11920000, 0,
    22700000, 8210000, 0, 15840000, 5723000, 0, 11359160, 4102000, 0,
    8110916, 2929000, 0, 5790346, 2091000, 0, 4109457, 1484000, 0,
    2899327, 1047000, 0, 2049190, 740000, 0, 1439971, 520000, 0,
    999949, 361100, 0, 690079, 249200, 0, 476021, 171900, 0,
    332301, 120000, 0, 234826, 84800, 0, 166151, 60000, 0,
    117413, 42400, 0, 83075, 30000, 0, 58707, 21200, 0,
    41510, 14990, 0, 29353, 10600, 0, 20674, 7470, 0,
    14560, 5260, 0, 10254, 3700, 0, 7225, 2610, 0,
    5100, 1840, 0, 3600, 1300, 0, 2545, 920, 0,
    1803, 650, 0, 1275, 460, 0
  };

  // One table entry: four-point Lagrange fit on the 5 nm nodes, clamped at
  // zero and rounded half up to Q2.16; x in the top field, z in the bottom.
  function automatic cmf_word_t cmf_entry(input int i);
    int     b;
    longint q;
    longint s;
    longint w [4];
    logic [17:0] v;
    cmf_word_t e;
    b = i / 5 - 1;
    if (b < 0) b = 0;
    if (b > NODE_COUNT - 4) b = NODE_COUNT - 4;
    q = longint'(i - 5 * b);
    w[0] = -((q - 5) * (q - 10) * (q - 15));
    w[1] = 3 * (q * (q - 10) * (q - 15));
    w[2] = -3 * (q * (q - 5) * (q - 15));
    w[3] = q * (q - 5) * (q - 10);
    e = '0;
    for (int c = 0; c < 3; c++) begin
      s = 0;
      for (int k = 0; k < 4; k++) begin
        s = s + w[k] * CIE_NODES[3 * (b + k) + c];
      end
      if (s < 0) s = 0;
      v = 18'((s * 65536 + 64'sd375000000000) / 64'sd750000000000);
      e[53 - 18 * c -: 18] = v;
    end
    return e;
  endfunction

  function automatic even_bank_t build_even();
    even_bank_t r;
    for (int j = 0; j < BANK_EVEN; j++) begin
      r[j] = cmf_entry(2 * j);
    end
    return r;
  endfunction

  function automatic odd_bank_t build_odd();
    odd_bank_t r;
    for (int j = 0; j < BANK_ODD; j++) begin
      r[j] = cmf_entry(2 * j + 1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/stxa_front.sv
// Front end: accepts sample words, checks them and reduces them to queue entries.
module stxa_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_contribution,
  input  logic [17:0]        in_wavelength_q8,
  input  logic [31:0]        in_pdf,
  input  logic               in_measure_ok,
  input  logic               in_last_lane,
  input  logic               q_full,
  output logic               q_push,
  output stxa_pkg::item_t    q_item
);
  import stxa_pkg::*;

  logic [17:0] coord;

  assign in_ready = !q_full;
  assign q_push = in_valid && !q_full;
  assign coord = in_wavelength_q8 - WL_MIN_Q8;

  always_comb begin
    q_item.neg = in_contribution[31];
    q_item.mag = in_contribution[31] ? (32'd0 - in_contribution) : in_contribution;
    q_item.idx = coord[16:8];
    q_item.frac = coord[7:0];
    q_item.pdf = in_pdf;
    q_item.invalid = (in_wavelength_q8 < WL_MIN_Q8) || (in_wavelength_q8 > WL_MAX_Q8) ||
                     (in_pdf == 32'd0) || !in_measure_ok;
    q_item.last = in_last_lane;
  end

endmodule

FILE: rtl/stxa_fifo.sv
// Short queue of checked sample words between the front and back ends.
module stxa_fifo #(
  parameter int DEPTH = stxa_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  stxa_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output stxa_pkg::item_t head,
  output logic            empty
);
  import stxa_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/stxa_back.sv
// Back end: table lookup, scaling, bit-serial divide, accumulation and result word.
module stxa_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        norm_scale,
  input  logic               q_empty,
  input  stxa_pkg::item_t    q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_sum_x,
  output logic signed [31:0] out_sum_y,
  output logic signed [31:0] out_sum_z,
  output logic [1:0]         out_error_code
);
  import stxa_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_INTERP = 4'd2;
  localparam logic [3:0] S_MUL1 = 4'd3;
  localparam logic [3:0] S_MUL2 = 4'd4;
  localparam logic [3:0] S_SUM = 4'd5;
  localparam logic [3:0] S_DIV = 4'd6;
  localparam logic [3:0] S_ACC = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  localparam int EAW = $clog2(BANK_EVEN);
  localparam int OAW = $clog2(BANK_ODD);
  localparam int CNTW = $clog2(QUO_W);
  localparam logic [QUO_W-1:0] Q_LIMIT = QUO_W'(1) << (QUO_W - 1);

  localparam even_bank_t ROM_EVEN = build_even();
  localparam odd_bank_t ROM_ODD = build_odd();

  logic [3:0]        state_r;
  logic [3:0]        state_nxt;
  item_t             cur_r;
  cmf_word_t         even_q_r;
  cmf_word_t         odd_q_r;
  logic [EAW-1:0]    even_addr;
  logic [OAW-1:0]    odd_addr;
  logic [RESP_W-1:0] resp_r [3];
  logic [PROD_W-1:0] p1_r [3];
  logic [PROD_W-1:0] hp_r [3];
  logic [31:0]       lp_r [3];
  logic [31:0]       rem_r [3];
  logic [QUO_W-1:0]  dvd_r [3];
  logic [QUO_W-1:0]  quo_r [3];
  logic              sat_r [3];
  logic [CNTW-1:0]   cnt_r;
  logic [31:0]       acc_r [3];
  logic [1:0]        sticky_r;
  logic              out_valid_r;
  logic [31:0]       out_x_r;
  logic [31:0]       out_y_r;
  logic [31:0]       out_z_r;
  logic [1:0]        out_err_r;

  logic [RESP_W-1:0] resp_nxt [3];
  logic [PROD_W-1:0] qsum [3];
  logic [31:0]       rem_nxt [3];
  logic              qbit [3];
  logic [35:0]       nsum [3];
  logic              any_ovf;
  logic              load_out;

  // Entry idx and idx+1 always sit in opposite banks.
  assign even_addr = EAW'(cur_r.idx[8:1]) + EAW'(cur_r.idx[0]);
  assign odd_addr = (cur_r.idx[8:1] > 8'(BANK_ODD - 1)) ? OAW'(BANK_ODD - 1) :
                    OAW'(cur_r.idx[8:1]);

  always_comb begin
    logic [17:0]        lo;
    logic [17:0]        hi;
    logic signed [18:0] diff;
    logic signed [27:0] resp_s;
    logic [33:0]        t;
    logic [QUO_W-1:0]   qv;
    logic signed [34:0] term;
    any_ovf = 1'b0;
    for (int c = 0; c < 3; c++) begin
      lo = cur_r.idx[0] ? odd_q_r[53 - 18 * c -: 18] : even_q_r[53 - 18 * c -: 18];
      hi = cur_r.idx[0] ? even_q_r[53 - 18 * c -: 18] : odd_q_r[53 - 18 * c -: 18];
      diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
      resp_s = $signed({2'b00, lo, 8'd0}) + 28'(diff) * 28'($signed({1'b0, cur_r.frac}));
      resp_nxt[c] = resp_s[RESP_W-1:0];

      qsum[c] = hp_r[c] + PROD_W'(lp_r[c]);

      t = {1'b0, rem_r[c], dvd_r[c][QUO_W-1]};
      qbit[c] = (t >= {2'b00, cur_r.pdf});
      rem_nxt[c] = qbit[c] ? 32'(t - {2'b00, cur_r.pdf}) : t[31:0];

      qv = (sat_r[c] || (quo_r[c] > Q_LIMIT)) ? Q_LIMIT : quo_r[c];
      term = cur_r.neg ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
      nsum[c] = 36'($signed(acc_r[c])) + 36'(term);
      if (nsum[c][35:31] != {5{nsum[c][31]}}) any_ovf = 1'b1;
    end
  end

  assign q_pop = (state_r == S_IDLE) && !q_empty;
  assign load_out = (state_r == S_DONE) && cur_r.last && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (!q_empty) state_nxt = S_CHECK;
      S_CHECK:  state_nxt = ((sticky_r != ERR_NONE) || cur_r.invalid) ? S_DONE : S_INTERP;
      S_INTERP: state_nxt = S_MUL1;
      S_MUL1:   state_nxt = S_MUL2;
      S_MUL2:   state_nxt = S_SUM;
      S_SUM:    state_nxt = S_DIV;
      S_DIV:    if (cnt_r == '0) state_nxt = S_ACC;
      S_ACC:    state_nxt = S_DONE;
      S_DONE:   if (!cur_r.last || load_out) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    even_q_r <= ROM_EVEN[even_addr];
    odd_q_r <= ROM_ODD[odd_addr];
    if (q_pop) begin
      cur_r <= q_head;
    end
    for (int c = 0; c < 3; c++) begin
      if (state_r == S_INTERP) resp_r[c] <= resp_nxt[c];
      if (state_r == S_MUL1) p1_r[c] <= PROD_W'(cur_r.mag) * PROD_W'(resp_r[c]);
      if (state_r == S_MUL2) begin
        hp_r[c] <= PROD_W'(p1_r[c][PROD_W-1:32]) * PROD_W'(norm_scale);
        lp_r[c] <= 32'((64'(p1_r[c][31:0]) * 64'(norm_scale)) >> 32);
      end
      if (state_r == S_SUM) begin
        // Quotients at or above 2^34 saturate; all, saturated or not, take QUO_W steps.
        rem_r[c] <= 32'(qsum[c][PROD_W-1:QUO_W]);
        sat_r[c] <= (32'(qsum[c][PROD_W-1:QUO_W]) >= cur_r.pdf);
        dvd_r[c] <= qsum[c][QUO_W-1:0];
        quo_r[c] <= '0;
      end
      if (state_r == S_DIV) begin
        rem_r[c] <= rem_nxt[c];
        dvd_r[c] <= {dvd_r[c][QUO_W-2:0], 1'b0};
        quo_r[c] <= {quo_r[c][QUO_W-2:0], qbit[c]};
      end
    end
    if (load_out) begin
      out_x_r <= (sticky_r != ERR_NONE) ? 32'd0 : acc_r[0];
      out_y_r <= (sticky_r != ERR_NONE) ? 32'd0 : acc_r[1];
      out_z_r <= (sticky_r != ERR_NONE) ? 32'd0 : acc_r[2];
      out_err_r <= sticky_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      sticky_r <= ERR_NONE;
      out_valid_r <= 1'b0;
      for (int c = 0; c < 3; c++) acc_r[c] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SUM) cnt_r <= CNTW'(QUO_W - 1);
      else if (state_r == S_DIV) cnt_r <= cnt_r - 1'b1;
      if ((state_r == S_CHECK) && (sticky_r == ERR_NONE) && cur_r.invalid) begin
        sticky_r <= ERR_INVALID;
      end
      if (state_r == S_ACC) begin
        if (any_ovf) begin
          sticky_r <= ERR_OVERFLOW;
        end else begin
          for (int c = 0; c < 3; c++) acc_r[c] <= nsum[c][31:0];
        end
      end
      if (load_out) begin
        sticky_r <= ERR_NONE;
        for (int c = 0; c < 3; c++) acc_r[c] <= '0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_sum_x = out_x_r;
  assign out_sum_y = out_y_r;
  assign out_sum_z = out_z_r;
  assign out_error_code = out_err_r;

endmodule

FILE: rtl/spectrum_to_xyz_accumulator_top.sv
// The back end finishes one sample word before it pops the next; a rejected or skipped
// sample goes from its check straight to done, and the others pass through the
// 34-step bit-serial divider of the back end; the queue takes words while it works.
// Reset: synchronous, active low; clears sums, error, queue, result valid flag and
// sets norm_scale to its default. The colour matching table is constant logic.
module spectrum_to_xyz_accumulator_top #(
  parameter int QUEUE_DEPTH = stxa_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_contribution,
  input  logic [17:0]        in_wavelength_q8,
  input  logic [31:0]        in_pdf,
  input  logic               in_measure_ok,
  input  logic               in_last_lane,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_sum_x,
  output logic signed [31:0] out_sum_y,
  output logic signed [31:0] out_sum_z,
  output logic [1:0]         out_error_code
);
  import stxa_pkg::*;

  logic [31:0] norm_scale_r;
  logic        q_full;
  logic        q_push;
  item_t       q_item;
  logic        q_pop;
  item_t       q_head;
  logic        q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_scale_r <= NORM_SCALE_RESET;
    end else if (cfg_valid) begin
      norm_scale_r <= cfg_data;
    end
  end

  stxa_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_contribution (in_contribution),
    .in_wavelength_q8(in_wavelength_q8),
    .in_pdf          (in_pdf),
    .in_measure_ok   (in_measure_ok),
    .in_last_lane    (in_last_lane),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_item)
  );

  stxa_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(q_item),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  stxa_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .norm_scale    (norm_scale_r),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sum_x     (out_sum_x),
    .out_sum_y     (out_sum_y),
    .out_sum_z     (out_sum_z),
    .out_error_code(out_error_code)
  );

endmodule

FILE: rtl/stxa_checker.sv
// Port-level checks on the accumulator's result channel, bound to the top level.
module stxa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_sum_x,
  input logic [31:0] out_sum_y,
  input logic [31:0] out_sum_z,
  input logic [1:0]  out_error_code
);
  import stxa_pkg::*;

  // A result word that is still waiting holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sum_x) && $stable(out_sum_y) &&
                                $stable(out_sum_z) && $stable(out_error_code))
    else $error("result word changed while stalled");

  // An error result carries zero sums.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code != ERR_NONE) |->
      (out_sum_x == 32'd0) && (out_sum_y == 32'd0) && (out_sum_z == 32'd0))
    else $error("error result with nonzero sums");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error_code == ERR_NONE) || (out_error_code == ERR_INVALID) ||
                  (out_error_code == ERR_OVERFLOW))
    else $error("undefined error code");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid straight after reset");

endmodule

bind spectrum_to_xyz_accumulator_top stxa_checker u_stxa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_sum_x     (out_sum_x),
  .out_sum_y     (out_sum_y),
  .out_sum_z     (out_sum_z),
  .out_error_code(out_error_code)
);

FILE: tb/tb.sv
// Self-checking testbench for the spectrum to XYZ accumulator.
module tb;
  import stxa_pkg::*;

  typedef struct {
    logic signed [31:0] contribution;
    logic [17:0]        wavelength_q8;
    logic [31:0]        pdf;
    logic               measure_ok;
    logic               last_lane;
  } sample_t;

  typedef struct {
    logic signed [31:0] sum_x;
    logic signed [31:0] sum_y;
    logic signed [31:0] sum_z;
    logic [1:0]         error_code;
  } tristim_t;

  typedef struct {
    sample_t  smp;
    bit       typed;
    tristim_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] in_contribution;
  logic [17:0] in_wavelength_q8;
  logic [31:0] in_pdf;
  logic in_measure_ok;
  logic in_last_lane;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_sum_x;
  logic signed [31:0] out_sum_y;
  logic signed [31:0] out_sum_z;
  logic [1:0] out_error_code;

  // Predictor state.
  longint cmf [TABLE_ENTRIES][3];
  logic [31:0] scale_q32;
  longint acc_xyz [3];
  logic [1:0] spec_err;

  tristim_t tristim_q [$];
  stim_row_t table_rows [$];
  int errors;
  bit no_idle;
  int hold_off;

  spectrum_to_xyz_accumulator_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_contribution(in_contribution), .in_wavelength_q8(in_wavelength_q8),
    .in_pdf(in_pdf), .in_measure_ok(in_measure_ok), .in_last_lane(in_last_lane),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sum_x(out_sum_x), .out_sum_y(out_sum_y), .out_sum_z(out_sum_z),
    .out_error_code(out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb: done, errors");
    $finish;
  end

  task automatic report(input string what);
    $display("tb: mismatch %s", what);
    errors++;
  endtask

  // Cubic fit on the four nodes around each nanometre, clamped and rounded to Q2.16.
  task automatic fill_cmf();
    longint b;
    longint q;
    longint s;
    longint w [4];
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      b = i / 5 - 1;
      if (b < 0) b = 0;
      if (b > NODE_COUNT - 4) b = NODE_COUNT - 4;
      q = i - 5 * b;
      w[0] = -((q - 5) * (q - 10) * (q - 15));
      w[1] = 3 * (q * (q - 10) * (q - 15));
      w[2] = -3 * (q * (q - 5) * (q - 15));
      w[3] = q * (q - 5) * (q - 10);
      for (int c = 0; c < 3; c++) begin
        s = 0;
        for (int k = 0; k < 4; k++) s += w[k] * CIE_NODES[3 * (b + k) + c];
        if (s < 0) s = 0;
        cmf[i][c] = ((s * 65536 + 64'sd375000000000) / 64'sd750000000000) & 18'h3FFFF;
      end
    end
  endtask

  // Folds one sample into the running sums; returns 1 when a spectrum closes.
  function automatic bit absorb_sample(input sample_t s, output tristim_t r);
    longint contrib;
    longint unsigned mag;
    longint unsigned p1;
    longint unsigned q;
    longint resp;
    longint nsum [3];
    longint idx;
    longint frac;
    bit ovf;
    contrib = longint'(s.contribution);
    r = '{0, 0, 0, ERR_NONE};
    if (spec_err == ERR_NONE) begin
      if (s.wavelength_q8 < WL_MIN_Q8 || s.wavelength_q8 > WL_MAX_Q8 || s.pdf == 0 ||
          !s.measure_ok) begin
        spec_err = ERR_INVALID;
      end else begin
        idx = longint'(s.wavelength_q8 - WL_MIN_Q8) >>> 8;
        frac = longint'(s.wavelength_q8 - WL_MIN_Q8) & 255;
        mag = contrib < 0 ? -contrib : contrib;
        ovf = 1'b0;
        for (int c = 0; c < 3; c++) begin
          if (idx + 1 >= TABLE_ENTRIES) resp = cmf[TABLE_ENTRIES - 1][c] * 256;
          else resp = cmf[idx][c] * 256 + (cmf[idx + 1][c] - cmf[idx][c]) * frac;
          p1 = mag * longint'(resp);
          q = (p1 >> 32) * scale_q32 + (((p1 & 64'hFFFFFFFF) * scale_q32) >> 32);
          q = q / s.pdf;
          if (q > 64'h200000000) q = 64'h200000000;
          nsum[c] = acc_xyz[c] + (contrib < 0 ? -longint'(q) : longint'(q));
          if (nsum[c] > 64'sd2147483647 || nsum[c] < -64'sd2147483648) ovf = 1'b1;
        end
        if (ovf) spec_err = ERR_OVERFLOW;
        else for (int c = 0; c < 3; c++) acc_xyz[c] = nsum[c];
      end
    end
    if (!s.last_lane) return 1'b0;
    if (spec_err == ERR_NONE) begin
      r.sum_x = acc_xyz[0][31:0];
      r.sum_y = acc_xyz[1][31:0];
      r.sum_z = acc_xyz[2][31:0];
    end
    r.error_code = spec_err;
    acc_xyz = '{0, 0, 0};
    spec_err = ERR_NONE;
    return 1'b1;
  endfunction

  task automatic write_scale(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    scale_q32 = v;
  endtask

  // Offers one word and predicts on acceptance; typed rows carry their own expectation.
  task automatic send_word(input sample_t s, input bit typed, input tristim_t want);
    tristim_t r;
    in_valid <= 1'b1;
    in_contribution <= s.contribution;
    in_wavelength_q8 <= s.wavelength_q8;
    in_pdf <= s.pdf;
    in_measure_ok <= s.measure_ok;
    in_last_lane <= s.last_lane;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (absorb_sample(s, r)) tristim_q.push_back(typed ? want : r);
    if (!no_idle && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tristim_q.size() != 0) @(posedge clk);
    // A word that closes no spectrum may still be in the divider.
    repeat (100) @(posedge clk);
  endtask

  function automatic sample_t random_sample(input bit last);
    sample_t s;
    int pick;
    s.last_lane = last;
    s.measure_ok = 1'b1;
    s.wavelength_q8 = 18'($urandom_range(WL_MIN_Q8, WL_MAX_Q8));
    if ($urandom_range(0, 9) == 0) s.wavelength_q8 = $urandom_range(0, 1) ? WL_MIN_Q8 : WL_MAX_Q8;
    s.pdf = $urandom_range(0, 3) == 0 ? $urandom | 32'd1 : $urandom_range(1 << 20, 1 << 28);
    s.contribution = $urandom_range(0, 3) == 0 ? $urandom
                   : $signed($urandom_range(0, 1 << 23)) - (1 << 22);
    pick = $urandom_range(0, 99);
    if (pick < 3) s.wavelength_q8 = 18'($urandom_range(0, WL_MIN_Q8 - 1));
    else if (pick < 6) s.wavelength_q8 = 18'($urandom_range(WL_MAX_Q8 + 1, 262143));
    else if (pick < 8) s.pdf = '0;
    else if (pick < 10) s.measure_ok = 1'b0;
    return s;
  endfunction

  task automatic add_row(input logic [31:0] c, input logic [17:0] wl, input logic [31:0] p,
                         input bit mok, input bit last, input bit typed, input logic [1:0] err);
    stim_row_t row;
    row.smp = '{c, wl, p, mok, last};
    row.typed = typed;
    row.want = '{0, 0, 0, err};
    table_rows.push_back(row);
  endtask

  task automatic random_spectra(input int count);
    int n;
    int len;
    tristim_t none;
    none = '{0, 0, 0, ERR_NONE};
    n = 0;
    while (n < count) begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) send_word(random_sample(k == len - 1), 1'b0, none);
      n += len;
    end
  endtask

  // Result side: checks each word against the oldest expectation and paces out_ready.
  initial begin
    tristim_t w;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (tristim_q.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          w = tristim_q.pop_front();
          if (out_sum_x !== w.sum_x) report($sformatf("sum_x %h want %h", out_sum_x, w.sum_x));
          if (out_sum_y !== w.sum_y) report($sformatf("sum_y %h want %h", out_sum_y, w.sum_y));
          if (out_sum_z !== w.sum_z) report($sformatf("sum_z %h want %h", out_sum_z, w.sum_z));
          if (out_error_code !== w.error_code)
            report($sformatf("error_code %0d want %0d", out_error_code, w.error_code));
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  initial begin
    logic [31:0] one_q16;
    logic [31:0] pdf_one;
    tristim_t none;
    errors = 0;
    no_idle = 1'b0;
    hold_off = 0;
    none = '{0, 0, 0, ERR_NONE};
    one_q16 = 32'h0001_0000;
    pdf_one = 32'h0100_0000;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_contribution = '0;
    in_wavelength_q8 = '0;
    in_pdf = '0;
    in_measure_ok = 1'b0;
    in_last_lane = 1'b0;
    fill_cmf();
    scale_q32 = NORM_SCALE_RESET;
    acc_xyz = '{0, 0, 0};
    spec_err = ERR_NONE;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: field extremes, each invalid cause, sticky errors and overflow.
    add_row('0, WL_MIN_Q8, pdf_one, 1, 1, 1, ERR_NONE);
    add_row(one_q16, WL_MIN_Q8 - 1, pdf_one, 1, 1, 1, ERR_INVALID);
    add_row(one_q16, WL_MAX_Q8, pdf_one, 1, 1, 0, ERR_NONE);
    add_row(one_q16, WL_MAX_Q8 + 1, pdf_one, 1, 1, 1, ERR_INVALID);
    add_row(one_q16, 18'h3FFFF, pdf_one, 1, 1, 1, ERR_INVALID);
    add_row(one_q16, 18'd0, pdf_one, 1, 1, 1, ERR_INVALID);
    add_row(one_q16, 18'd142080, 32'd0, 1, 1, 1, ERR_INVALID);
    add_row(one_q16, 18'd142080, pdf_one, 0, 1, 1, ERR_INVALID);
    add_row(one_q16, 18'd142080, pdf_one, 1, 0, 0, ERR_NONE);
    add_row(one_q16, 18'd142208, pdf_one, 1, 0, 0, ERR_NONE);
    add_row(32'hFFFF_0000, 18'd142143, pdf_one, 1, 1, 0, ERR_NONE);
    add_row(one_q16, 18'd0, pdf_one, 1, 0, 0, ERR_NONE);
    add_row(one_q16, 18'd142080, pdf_one, 1, 1, 1, ERR_INVALID);
    add_row(32'h7FFF_FFFF, 18'd142080, 32'd1, 1, 1, 1, ERR_OVERFLOW);
    add_row(32'h8000_0000, 18'd142080, 32'd1, 1, 0, 0, ERR_NONE);
    add_row(one_q16, 18'd142080, pdf_one, 1, 1, 1, ERR_OVERFLOW);
    add_row(32'h8000_0000, 18'd150000, 32'hFFFF_FFFF, 1, 1, 0, ERR_NONE);
    add_row(32'h7FFF_FFFF, 18'd100000, 32'hFFFF_FFFF, 1, 1, 0, ERR_NONE);
    add_row(one_q16, 18'd92416, 32'h0000_0100, 1, 1, 0, ERR_NONE);
    foreach (table_rows[i]) send_word(table_rows[i].smp, table_rows[i].typed, table_rows[i].want);
    drain();

    write_scale(32'd0);
    random_spectra(200);
    drain();

    // A long stretch with no idling on either side.
    write_scale(32'hFFFF_FFFF);
    no_idle = 1'b1;
    random_spectra(250);
    drain();
    no_idle = 1'b0;

    // The receiver holds off while single-word spectra keep coming.
    write_scale($urandom);
    hold_off = 600;
    for (int k = 0; k < 12; k++) send_word(random_sample(1'b1), 1'b0, none);
    random_spectra(200);
    drain();

    write_scale(32'd1);
    random_spectra(200);
    drain();

    write_scale(NORM_SCALE_RESET);
    random_spectra(450);
    drain();

    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
